// ===== rtl/stt_pkg.sv =====
// Shared types, token kind codes and character classifiers for the source text tokenizer.
// Used by stt_core, stt_res_queue and source_text_tokenizer_unit; no dependencies.
package stt_pkg;

    // Default build constants
    localparam int KEYWORD_MAX_LEN_DEF = 6;
    localparam int OFFSET_BITS_DEF     = 32;
    localparam int LINE_BITS_DEF       = 24;

    // Longest keyword in the table
    localparam int KW_LEN_MAX = 6;
    localparam int KW_COUNT   = 12;

    // Result queue depth (two slots must be free to take a byte)
    localparam int QDEPTH = 4;
    localparam int QPTRW  = $clog2(QDEPTH);

    // Token kind codes
    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_KEYWORD = 5'd1;
    localparam logic [4:0] KIND_INT     = 5'd2;
    localparam logic [4:0] KIND_SYM0    = 5'd3;
    localparam logic [4:0] KIND_EQ      = 5'd23;
    localparam logic [4:0] KIND_NE      = 5'd24;
    localparam logic [4:0] KIND_LE      = 5'd25;
    localparam logic [4:0] KIND_GE      = 5'd26;
    localparam logic [4:0] KIND_UNKNOWN = 5'd27;
    localparam logic [4:0] KIND_NONE    = 5'd0;

    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Keywords, first character in the top byte, zero padded on the right
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'("return"), {"var", 24'h0}, {"for", 24'h0}, {"while", 8'h0},
        {"loop", 16'h0}, {"int8", 16'h0}, {"int16", 8'h0}, {"int32", 8'h0},
        {"int64", 8'h0}, {"char", 16'h0}, {"float", 8'h0}, {"void", 16'h0}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd3, 3'd3, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4
    };

    typedef logic [KW_LEN_MAX-1:0][7:0] t_kw_prefix;

    // One token descriptor
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [23:0] line;
        logic [31:0] num;
        logic        last;
    } t_token;

    // Results of one byte: zero, one or two tokens
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
               (b == 8'h0C) || (b == 8'h0D);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // Single symbol kind 3..22, zero for anything else
    function automatic logic [4:0] sym_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            "(":     k = 5'd3;
            ")":     k = 5'd4;
            "{":     k = 5'd5;
            "}":     k = 5'd6;
            "[":     k = 5'd7;
            "]":     k = 5'd8;
            ":":     k = 5'd9;
            ";":     k = 5'd10;
            ">":     k = 5'd11;
            "<":     k = 5'd12;
            "=":     k = 5'd13;
            "\"":    k = 5'd14;
            ",":     k = 5'd15;
            ".":     k = 5'd16;
            "+":     k = 5'd17;
            "-":     k = 5'd18;
            "*":     k = 5'd19;
            "/":     k = 5'd20;
            "!":     k = 5'd21;
            "%":     k = 5'd22;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Two-character comparison kind for a lead character, zero otherwise
    function automatic logic [4:0] cmp_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            "=":     k = KIND_EQ;
            "!":     k = KIND_NE;
            "<":     k = KIND_LE;
            ">":     k = KIND_GE;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Parallel compare of the word prefix against every keyword
    function automatic logic kw_match(input t_kw_prefix pfx, input logic [31:0] len);
        logic hit;
        logic same;
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            same = (len == 32'(KW_LEN[i]));
            for (int j = 0; j < KW_LEN_MAX; j++) begin
                if (j < int'(KW_LEN[i]) && pfx[j] != KW_TEXT[i][47-8*j -: 8]) begin
                    same = 1'b0;
                end
            end
            hit = hit | same;
        end
        return hit;
    endfunction

endpackage

// ===== rtl/stt_core.sv =====
// Scanner state and per-byte token decision for the source text tokenizer.
// Depends on stt_pkg; produces up to two token descriptors per accepted byte.
module stt_core
    import stt_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
    parameter int LINE_BITS       = LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output t_push      o_push
);

    localparam int IDXW = $clog2(KEYWORD_MAX_LEN);

    // Scan modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_HELD   = 2'd3;

    logic [1:0]             r_mode, n_mode;
    logic [7:0]             r_held, n_held;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [31:0]            r_bytes, n_bytes;
    logic [7:0]             r_prefix [KEYWORD_MAX_LEN];
    logic [7:0]             n_prefix [KEYWORD_MAX_LEN];
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [31:0]            r_tok, n_tok;

    logic                   sp, alpha, digit, consumed;
    logic [4:0]             sk, ck;
    logic [31:0]            bytes_inc, tok1, tok2;
    logic                   e_a, e_b, e_c;
    t_token                 t_a, t_b, t_c, t_x;
    t_kw_prefix             pfx_cur, pfx_nxt;

    // Build a descriptor; offset and line are cut or zero-extended to port width
    function automatic t_token mk_tok(input logic [4:0] kind,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [31:0] len,
                                      input logic [LINE_BITS-1:0] line);
        t_token t;
        logic [OFFSET_BITS+31:0] s_ext;
        logic [LINE_BITS+23:0]   l_ext;
        s_ext  = {32'd0, start};
        l_ext  = {24'd0, line};
        t.kind  = kind;
        t.start = s_ext[31:0];
        t.len   = len;
        t.line  = l_ext[23:0];
        t.num   = 32'd0;
        t.last  = 1'b0;
        return t;
    endfunction

    always_comb begin
        sp    = is_space(i_byte);
        alpha = is_alpha(i_byte);
        digit = is_digit(i_byte);
        sk    = sym_kind(i_byte);
        ck    = cmp_kind(i_byte);

        n_mode   = r_mode;
        n_held   = r_held;
        n_start  = r_start;
        n_bytes  = r_bytes;
        n_prefix = r_prefix;
        n_line   = r_line;
        n_off    = r_off;
        consumed = 1'b0;
        e_a      = 1'b0;
        e_b      = 1'b0;
        e_c      = 1'b0;
        t_a      = '0;
        t_b      = '0;
        t_c      = '0;

        bytes_inc = (r_bytes == 32'hFFFF_FFFF) ? r_bytes : r_bytes + 32'd1;
        for (int j = 0; j < KW_LEN_MAX; j++) begin
            pfx_cur[j] = r_prefix[j];
        end

        // Pending token: extend it or close it
        case (r_mode)
            MODE_WORD: begin
                if (sp || sk != KIND_NONE) begin
                    e_a    = 1'b1;
                    t_a    = mk_tok(kw_match(pfx_cur, r_bytes) ? KIND_KEYWORD : KIND_IDENT,
                                    r_start, r_bytes, r_line);
                    n_mode = MODE_IDLE;
                end else begin
                    if (r_bytes < 32'(KEYWORD_MAX_LEN)) begin
                        n_prefix[r_bytes[IDXW-1:0]] = i_byte;
                    end
                    n_bytes  = bytes_inc;
                    consumed = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (digit) begin
                    n_bytes  = bytes_inc;
                    consumed = 1'b1;
                end else begin
                    e_a    = 1'b1;
                    t_a    = mk_tok(KIND_INT, r_start, r_bytes, r_line);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_HELD: begin
                e_a    = 1'b1;
                n_mode = MODE_IDLE;
                if (i_byte == "=") begin
                    t_a      = mk_tok(cmp_kind(r_held), r_start, 32'd2, r_line);
                    consumed = 1'b1;
                end else begin
                    t_a = mk_tok(sym_kind(r_held), r_start, 32'd1, r_line);
                end
            end
            default: ;
        endcase

        // Byte not absorbed: start a token or emit a one-byte token
        if (!consumed && !sp) begin
            if (alpha) begin
                n_mode      = MODE_WORD;
                n_start     = r_off;
                n_bytes     = 32'd1;
                n_prefix[0] = i_byte;
            end else if (digit) begin
                n_mode  = MODE_NUMBER;
                n_start = r_off;
                n_bytes = 32'd1;
            end else if (ck != KIND_NONE) begin
                n_mode  = MODE_HELD;
                n_held  = i_byte;
                n_start = r_off;
            end else begin
                e_b = 1'b1;
                t_b = mk_tok((sk != KIND_NONE) ? sk : KIND_UNKNOWN, r_off, 32'd1, r_line);
            end
        end

        // Saturating position counters
        if (i_byte == CHAR_LF && r_line != '1) begin
            n_line = r_line + 1'b1;
        end
        if (r_off != '1) begin
            n_off = r_off + 1'b1;
        end

        // End of text: flush what is still open, on the updated line
        for (int j = 0; j < KW_LEN_MAX; j++) begin
            pfx_nxt[j] = n_prefix[j];
        end
        if (i_eot) begin
            case (n_mode)
                MODE_WORD: begin
                    e_c = 1'b1;
                    t_c = mk_tok(kw_match(pfx_nxt, n_bytes) ? KIND_KEYWORD : KIND_IDENT,
                                 n_start, n_bytes, n_line);
                end
                MODE_NUMBER: begin
                    e_c = 1'b1;
                    t_c = mk_tok(KIND_INT, n_start, n_bytes, n_line);
                end
                MODE_HELD: begin
                    e_c = 1'b1;
                    t_c = mk_tok(sym_kind(n_held), n_start, 32'd1, n_line);
                end
                default: ;
            endcase
        end

        // Order the results and number them
        tok1 = (r_tok == 32'hFFFF_FFFF) ? r_tok : r_tok + 32'd1;
        tok2 = (tok1 == 32'hFFFF_FFFF) ? tok1 : tok1 + 32'd1;
        t_x  = e_b ? t_b : t_c;

        o_push.cnt  = 2'(e_a) + 2'(e_b) + 2'(e_c);
        o_push.tok0 = e_a ? t_a : t_x;
        o_push.tok1 = e_a ? t_x : t_c;
        o_push.tok0.num  = r_tok;
        o_push.tok1.num  = tok1;
        o_push.tok0.last = (o_push.cnt == 2'd1);
        o_push.tok1.last = 1'b1;

        case (o_push.cnt)
            2'd0:    n_tok = r_tok;
            2'd1:    n_tok = tok1;
            default: n_tok = tok2;
        endcase

        // Full state reset after the final byte
        if (i_eot) begin
            n_mode  = MODE_IDLE;
            n_held  = 8'd0;
            n_start = '0;
            n_bytes = 32'd0;
            n_line  = LINE_BITS'(1);
            n_off   = '0;
            n_tok   = 32'd0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_held  <= 8'd0;
            r_start <= '0;
            r_bytes <= 32'd0;
            r_line  <= LINE_BITS'(1);
            r_off   <= '0;
            r_tok   <= 32'd0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_start <= n_start;
            r_bytes <= n_bytes;
            r_line  <= n_line;
            r_off   <= n_off;
            r_tok   <= n_tok;
        end
    end

    // Word prefix, no reset: only written entries are ever compared
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prefix <= n_prefix;
        end
    end

endmodule

// ===== rtl/stt_res_queue.sv =====
// Small result queue for token descriptors: takes up to two per cycle, gives one while the reader is ready.
// Depends on stt_pkg (t_push, t_token, QDEPTH).
module stt_res_queue
    import stt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_tok
);

    t_token              r_q [QDEPTH];
    logic [QPTRW-1:0]    r_head, n_head;
    logic [QPTRW-1:0]    r_tail, n_tail;
    logic [QPTRW:0]      r_count, n_count;
    logic [QPTRW-1:0]    tail1;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_tok   = r_q[r_head];
    assign o_room  = (r_count <= (QPTRW+1)'(QDEPTH - 2));
    assign pop     = o_valid & i_ready;
    assign tail1   = r_tail + 1'b1;

    // Pointer and fill count update
    always_comb begin
        n_head  = r_head + QPTRW'(pop);
        n_tail  = r_tail + QPTRW'(i_push.cnt);
        n_count = r_count + (QPTRW+1)'(i_push.cnt) - (QPTRW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Entry writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[r_tail] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[tail1] <= i_push.tok1;
        end
    end

endmodule

// ===== rtl/source_text_tokenizer_unit.sv =====
// Top level of the source text tokenizer: stream ports around the scanner and result queue.
// Depends on stt_pkg, stt_core and stt_res_queue.
//
// Takes one text byte per cycle and returns token descriptors. A byte is
// processed in the cycle it is accepted; its zero, one or two tokens enter a
// four-entry result queue and leave one per cycle while the output is ready.
// The input is ready whenever at least two queue slots are free, so with the
// output side ready the block sustains one byte per clock; the extra token
// of a two-token byte is absorbed by the queue. No clearing pass after reset.
// A first token is registered and offered next cycle if the queue was empty.
module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
    parameter int LINE_BITS       = LINE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] text_byte
    input  logic         s_axis_tlast,   // end_of_text
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [4:0] token_kind, [36:5] start_offset,
                                         // [68:37] token_length, [92:69] line_number,
                                         // [124:93] token_number, [127:125] zero
    output logic         m_axis_tlast    // run_last
);

    logic   accept;
    logic   room;
    t_push  push;
    t_token tok;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid & room;

    // Scanner
    stt_core #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .OFFSET_BITS     (OFFSET_BITS),
        .LINE_BITS       (LINE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .o_push   (push)
    );

    // Result queue; nothing is pushed unless a byte is accepted
    t_push push_q;
    always_comb begin
        push_q = push;
        if (!accept) begin
            push_q.cnt = 2'd0;
        end
    end

    stt_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_q),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (tok)
    );

    // Output packing
    assign m_axis_tdata = {3'b000, tok.num, tok.line, tok.len, tok.start, tok.kind};
    assign m_axis_tlast = tok.last;

endmodule

// ===== tb/token_stream_checker.sv =====
// Scoreboard for the source text tokenizer: predicts token descriptors from accepted bytes.
// Depends on stt_pkg for the token kind codes and the keyword window length.
module token_stream_checker
    import stt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,    // [7:0] text_byte
    input  logic         i_s_tlast,    // end_of_text
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [127:0] i_m_tdata,    // [4:0] kind, [36:5] start, [68:37] length,
                                       // [92:69] line, [124:93] token index
    input  logic         i_m_tlast,    // run_last
    output logic [31:0]  o_fails,
    output logic [31:0]  o_bytes_in,
    output logic [31:0]  o_tokens_due,
    output logic [31:0]  o_tokens_seen
);

    localparam int          KW_WINDOW  = KEYWORD_MAX_LEN_DEF;
    localparam logic [31:0] COUNT_TOP  = 32'hFFFF_FFFF;
    localparam logic [31:0] OFFSET_TOP = 32'hFFFF_FFFF;
    localparam logic [23:0] LINE_TOP   = 24'hFF_FFFF;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_HELD} t_scan_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [23:0] line;
        logic [31:0] num;
        logic        last;
    } t_exp_token;

    string kw_names [12] = '{"return", "var", "for", "while", "loop", "int8",
                             "int16", "int32", "int64", "char", "float", "void"};
    string punct_order = "(){}[]:;><=\",.+-*/!%";

    // Lexer state mirror
    t_scan_mode  mode;
    logic [7:0]  held;
    logic [31:0] tok_start;
    logic [31:0] tok_len;
    logic [7:0]  prefix [KW_WINDOW];
    logic [23:0] line_no;
    logic [31:0] offset;
    logic [31:0] tok_count;

    t_exp_token  step_buf [2];
    int          step_n;
    t_exp_token  tokens_due [$];
    int          fails;
    int          bytes_in;
    int          tokens_seen;

    function automatic logic blank_char(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Single-character symbol kind, KIND_NONE when not a symbol
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        k = KIND_NONE;
        for (int i = 0; i < 20; i++) begin
            if (punct_order[i] == c) k = KIND_SYM0 + 5'(i);
        end
        return k;
    endfunction

    function automatic logic [4:0] pair_kind(input logic [7:0] c);
        case (c)
            "=":     return KIND_EQ;
            "!":     return KIND_NE;
            "<":     return KIND_LE;
            ">":     return KIND_GE;
            default: return KIND_NONE;
        endcase
    endfunction

    // Current word against the keyword list; only short words can match
    function automatic logic word_reserved();
        logic hit;
        logic same;
        hit = 1'b0;
        if (tok_len <= KW_WINDOW) begin
            for (int i = 0; i < 12; i++) begin
                same = (tok_len == kw_names[i].len());
                for (int j = 0; j < kw_names[i].len(); j++) begin
                    if (same && prefix[j] != kw_names[i][j]) same = 1'b0;
                end
                hit = hit | same;
            end
        end
        return hit;
    endfunction

    task automatic add_token(input logic [4:0] kind, input logic [31:0] start,
                             input logic [31:0] len);
        t_exp_token t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.line  = line_no;
        t.num   = tok_count;
        t.last  = 1'b0;
        step_buf[step_n] = t;
        step_n = step_n + 1;
        if (tok_count != COUNT_TOP) tok_count = tok_count + 1;
    endtask

    // Emit whatever token is still open
    task automatic flush_token();
        case (mode)
            SCAN_WORD:   add_token(word_reserved() ? KIND_KEYWORD : KIND_IDENT,
                                   tok_start, tok_len);
            SCAN_NUMBER: add_token(KIND_INT, tok_start, tok_len);
            SCAN_HELD:   add_token(punct_kind(held), tok_start, 32'd1);
            default: ;
        endcase
        mode = SCAN_IDLE;
    endtask

    task automatic clear_scan();
        mode      = SCAN_IDLE;
        held      = 8'h00;
        tok_start = '0;
        tok_len   = '0;
        for (int i = 0; i < KW_WINDOW; i++) prefix[i] = 8'h00;
        line_no   = 24'd1;
        offset    = '0;
        tok_count = '0;
    endtask

    // One accepted byte: update the mirror and queue its tokens
    task automatic scan_byte(input logic [7:0] c, input logic eot);
        logic       used;
        logic [4:0] pk;
        t_exp_token t;
        used   = 1'b0;
        step_n = 0;
        case (mode)
            SCAN_WORD: begin
                if (blank_char(c) || punct_kind(c) != KIND_NONE) begin
                    flush_token();
                end else begin
                    if (tok_len < KW_WINDOW) prefix[tok_len] = c;
                    if (tok_len != COUNT_TOP) tok_len = tok_len + 1;
                    used = 1'b1;
                end
            end
            SCAN_NUMBER: begin
                if (digit_char(c)) begin
                    if (tok_len != COUNT_TOP) tok_len = tok_len + 1;
                    used = 1'b1;
                end else begin
                    flush_token();
                end
            end
            SCAN_HELD: begin
                if (c == "=") begin
                    add_token(pair_kind(held), tok_start, 32'd2);
                    mode = SCAN_IDLE;
                    used = 1'b1;
                end else begin
                    flush_token();
                end
            end
            default: ;
        endcase

        // Start a new token unless the byte was taken above
        if (!used && !blank_char(c)) begin
            if (letter_char(c)) begin
                mode      = SCAN_WORD;
                tok_start = offset;
                tok_len   = 32'd1;
                prefix[0] = c;
            end else if (digit_char(c)) begin
                mode      = SCAN_NUMBER;
                tok_start = offset;
                tok_len   = 32'd1;
            end else if (pair_kind(c) != KIND_NONE) begin
                mode      = SCAN_HELD;
                held      = c;
                tok_start = offset;
            end else begin
                pk = punct_kind(c);
                add_token(pk != KIND_NONE ? pk : KIND_UNKNOWN, offset, 32'd1);
            end
        end

        if (c == 8'h0A && line_no != LINE_TOP) line_no = line_no + 1;
        if (offset != OFFSET_TOP) offset = offset + 1;

        if (eot) begin
            flush_token();
            clear_scan();
        end

        for (int i = 0; i < step_n; i++) begin
            t = step_buf[i];
            t.last = (i == step_n - 1);
            tokens_due.push_back(t);
        end
    endtask

    // Compare one delivered descriptor with the oldest prediction
    task automatic check_token();
        t_exp_token got;
        t_exp_token want;
        got.kind  = i_m_tdata[4:0];
        got.start = i_m_tdata[36:5];
        got.len   = i_m_tdata[68:37];
        got.line  = i_m_tdata[92:69];
        got.num   = i_m_tdata[124:93];
        got.last  = i_m_tlast;
        tokens_seen = tokens_seen + 1;
        if (tokens_due.size() == 0) begin
            if (fails < 10) begin
                $display("unexpected token: kind %0d start %0d len %0d line %0d num %0d last %0b",
                         got.kind, got.start, got.len, got.line, got.num, got.last);
            end
            fails = fails + 1;
        end else begin
            want = tokens_due.pop_front();
            if (got.kind != want.kind || got.start != want.start || got.len != want.len ||
                got.line != want.line || got.num != want.num || got.last != want.last) begin
                if (fails < 10) begin
                    $display("token mismatch at %0t", $realtime);
                    $display("  expected kind %0d start %0d len %0d line %0d num %0d last %0b",
                             want.kind, want.start, want.len, want.line, want.num, want.last);
                    $display("  actual   kind %0d start %0d len %0d line %0d num %0d last %0b",
                             got.kind, got.start, got.len, got.line, got.num, got.last);
                end
                fails = fails + 1;
            end
        end
    endtask

    // Watch both channels on every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            tokens_due.delete();
            fails       = 0;
            bytes_in    = 0;
            tokens_seen = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) check_token();
            if (i_s_tvalid && i_s_tready) begin
                scan_byte(i_s_tdata, i_s_tlast);
                bytes_in = bytes_in + 1;
            end
        end
        o_fails       <= fails;
        o_bytes_in    <= bytes_in;
        o_tokens_due  <= tokens_due.size();
        o_tokens_seen <= tokens_seen;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the tokenizer testbench: clock, reset, byte stimulus, output stalls and verdict.
// Depends on source_text_tokenizer_unit and token_stream_checker.
module testbench;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic         s_axis_tlast = 1'b0;    // end_of_text
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;           // [4:0] kind .. [124:93] token index
    logic         m_axis_tlast;           // run_last

    logic [31:0]  fails;
    logic [31:0]  bytes_in;
    logic [31:0]  tokens_due;
    logic [31:0]  tokens_seen;

    logic         tx_steady = 1'b0;
    logic         rx_steady = 1'b0;
    logic [7:0]   text_q [$];
    int           texts_sent = 0;

    string kw_pool [12] = '{"return", "var", "for", "while", "loop", "int8",
                            "int16", "int32", "int64", "char", "float", "void"};
    string near_miss [10] = '{"returns", "int", "int1", "int128", "Var", "fo",
                              "whil", "voids", "floaty", "Char"};
    string punct_chars = "(){}[]:;><=\",.+-*/!%";
    string cmp_chars = "=!<>";
    string odd_chars = "@#$&'?^|~\\_";

    source_text_tokenizer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    token_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .o_fails       (fails),
        .o_bytes_in    (bytes_in),
        .o_tokens_due  (tokens_due),
        .o_tokens_seen (tokens_seen)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("[source_text_tokenizer_unit] ERROR");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(input logic steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one byte and wait until the request is taken
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        int want;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        want = bytes_in + 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        while (bytes_in != want) @(negedge i_clk);
    endtask

    task automatic send_str(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 8'h20;
        if (r < 8) return 8'h0A;
        return 8'($urandom_range(9, 13));
    endfunction

    // Byte that starts an unknown-symbol token
    function automatic logic [7:0] rand_odd();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return odd_chars[$urandom_range(0, odd_chars.len() - 1)];
        if (r < 8) return 8'($urandom_range(128, 255));
        if (r == 8) return 8'h00;
        return $urandom_range(0, 1) ? 8'h7F : 8'($urandom_range(1, 8));
    endfunction

    // Identifier tail byte: anything that does not end a word
    function automatic logic [7:0] rand_word_tail();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return rand_letter();
        if (r < 14) return 8'($urandom_range(48, 57));
        if (r < 16) return "_";
        if (r < 18) return 8'($urandom_range(128, 255));
        return r == 18 ? 8'h00 : "@";
    endfunction

    // One lexical piece of a well-formed text
    task automatic add_piece();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 14) begin
            push_str(kw_pool[$urandom_range(0, 11)]);
        end else if (sel < 18) begin
            push_str(near_miss[$urandom_range(0, 9)]);
        end else if (sel < 38) begin
            text_q.push_back(rand_letter());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
            repeat (n) text_q.push_back(rand_word_tail());
        end else if (sel < 52) begin
            repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(48, 57)));
        end else if (sel < 67) begin
            text_q.push_back(punct_chars[$urandom_range(0, 19)]);
        end else if (sel < 80) begin
            text_q.push_back(cmp_chars[$urandom_range(0, 3)]);
            if ($urandom_range(0, 4) != 0) text_q.push_back("=");
        end else if (sel < 86) begin
            text_q.push_back(rand_odd());
        end else begin
            text_q.push_back(rand_blank());
        end
    endtask

    // Build and send one text, the last byte flagged as end of text
    task automatic send_text();
        text_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 12)) begin
                add_piece();
                if ($urandom_range(0, 9) < 6) text_q.push_back(rand_blank());
            end
        end
        tx_steady = ($urandom_range(0, 5) == 0);
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
        texts_sent++;
    endtask

    // Output side: random stalls, quiet stretches, and two long hold-offs
    initial begin : sink
        int holds_done;
        int r;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if ((holds_done == 0 && bytes_in >= 300) ||
                (holds_done == 1 && bytes_in >= 1000)) begin
                m_axis_tready <= 1'b0;
                repeat (150) @(negedge i_clk);
                holds_done++;
            end else begin
                if ($urandom_range(0, 79) == 0) rx_steady = !rx_steady;
                r = $urandom_range(0, 99);
                if (rx_steady) begin
                    m_axis_tready <= 1'b1;
                end else if (r < 3) begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(8, 25)) @(negedge i_clk);
                end else begin
                    m_axis_tready <= (r >= 30);
                end
            end
        end
    end

    // Reset, directed texts, random texts, drain and verdict
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // keyword, identifier with high byte, ==, integer then letter, !=, held < then letter
        send_str("int16 v", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_str("9==42x!=<y", 1'b1);
        // NUL and other unknowns, newline, end of text while a comparison is held
        send_byte(8'h00, 1'b0);
        send_str("@\n>", 1'b1);
        // end of text on whitespace after a keyword
        send_str("for\n", 1'b1);
        texts_sent = 3;

        while (bytes_in < 1425) send_text();

        s_axis_tvalid <= 1'b0;
        while (tokens_due != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Run covered %0d bytes in %0d texts; %0d token descriptors compared, %0d failures.",
                 bytes_in, texts_sent, tokens_seen, fails);
        if (fails == 0) begin
            $display("[source_text_tokenizer_unit] OK");
        end else begin
            $display("[source_text_tokenizer_unit] ERROR");
        end
        $finish;
    end

endmodule
